@@ src/fpp_pkg.sv @@
// Frame-period pacer package: widths, codes and payload types shared by the
// pacer modules, the channel interfaces and the checker. No dependencies.
`default_nettype none

package fpp_pkg;

	localparam int TIME_W     = 63;
	localparam int PERIOD_W   = 32;
	localparam int FRAC_W     = 16;
	localparam int WAIT_W     = 33;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Elapsed main-clock readings above this are treated as implausible.
	localparam logic signed [TIME_W:0] MAIN_LIMIT_NS = 64'sd500000000;

	typedef enum logic [0:0] {
		OP_RESTART = 1'b0,
		OP_POLL    = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD_NS       = 1'b0,
		CFG_PERIOD_FRACTION = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t                 operation;
		logic [TIME_W-1:0]   main_time_ns;
		logic [TIME_W-1:0]   aux_time_ns;
	} item_t;

	typedef struct packed {
		logic                period_done;
		logic [PERIOD_W-1:0] lateness_ns;
		logic [WAIT_W-1:0]   next_wait_ns;
	} result_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ns;
		logic [FRAC_W-1:0]   period_fraction;
	} cfg_t;

endpackage

`default_nettype wire

@@ src/fpp_if.sv @@
// Valid/ready channel interfaces for pacer input items and result items.
// Depends on fpp_pkg for the payload types.
`default_nettype none

interface fpp_item_if import fpp_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fpp_result_if import fpp_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/frame_period_pacer_core.sv @@
// Frame-period pacer top level: input register, configuration registers,
// state update and result register. Depends on fpp_pkg, fpp_if, fpp_cfg_regs
// and fpp_pacer_step.
//
// Each item is a restart or a poll with a main and an auxiliary nanosecond
// timestamp; every item yields exactly one result (period_done, lateness_ns,
// next_wait_ns). The block takes one item per clock cycle while the result side
// keeps up. An accepted item sits in the input register, is evaluated against
// the pacer state in a single pass, and its result is loaded into the result
// register once that register is empty or being taken; the result is then
// presented from the result register until the result side takes it. The
// input register and the result register form two slots, so a new item is
// accepted while a finished result waits to be taken; items only stall when
// both are full and the result is not being taken. The period registers are
// written through the plain write port and must only change while no item is
// in flight.
`default_nettype none

module frame_period_pacer_core import fpp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	fpp_item_if.sink                   items,
	fpp_result_if.source               results
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_result;
	result_t result_q;
	logic    res_valid_q;
	logic    advance;
	logic    commit;

	fpp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fpp_pacer_step u_pacer_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.commit (commit),
		.result (step_result)
	);

	// Move the input register forward whenever the result register frees up
	assign advance       = !res_valid_q || results.ready;
	assign commit        = valid_s1 && advance;
	assign items.ready   = !valid_s1 || advance;

	// Capture the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.payload;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= step_result;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.payload = result_q;

endmodule

`default_nettype wire

@@ src/fpp_cfg_regs.sv @@
// Configuration registers of the pacer: whole and fractional period.
// Depends on fpp_pkg.
`default_nettype none

module fpp_cfg_regs import fpp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD_NS: begin
					cfg_q.period_ns <= cfg_wdata[PERIOD_W-1:0];
				end
				CFG_PERIOD_FRACTION: begin
					cfg_q.period_fraction <= cfg_wdata[FRAC_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/fpp_pacer_step.sv @@
// Pacer state (references, wait length, fraction accumulator, poll count)
// and the single-pass update that one item applies to it. Depends on fpp_pkg.
`default_nettype none

module fpp_pacer_step import fpp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  commit,
	output result_t    result
);

	logic [TIME_W-1:0] main_ref_q;
	logic [TIME_W-1:0] aux_ref_q;
	logic [WAIT_W-1:0] wait_q;
	logic [FRAC_W-1:0] frac_acc_q;
	logic [1:0]        polls_q;

	logic signed [TIME_W:0] el_main;
	logic signed [TIME_W:0] el_aux;
	logic signed [TIME_W:0] el;
	logic signed [TIME_W:0] wl;
	logic                   main_bad;
	logic                   reached;
	logic                   first;
	logic [TIME_W:0]        late_full;
	logic                   over;
	logic [FRAC_W:0]        frac_sum;
	logic [FRAC_W:0]        frac_in;
	logic [WAIT_W-1:0]      base_wait;
	logic [WAIT_W-1:0]      end_wait;
	logic [PERIOD_W-1:0]    end_late;
	logic                   latch_refs;
	logic [WAIT_W-1:0]      wait_d;
	logic [FRAC_W-1:0]      frac_d;
	logic [1:0]             polls_d;

	// Measure elapsed time, fall back to the aux clock on an implausible reading, and to the wait length if aux steps back
	always_comb begin
		el_main  = signed'({1'b0, item.main_time_ns}) - signed'({1'b0, main_ref_q});
		el_aux   = signed'({1'b0, item.aux_time_ns}) - signed'({1'b0, aux_ref_q});
		wl       = signed'({{(TIME_W+1-WAIT_W){1'b0}}, wait_q});
		main_bad = (el_main <= 0) || (el_main > MAIN_LIMIT_NS);
		if (!main_bad) begin
			el = el_main;
		end else if (el_aux < 0) begin
			el = wl;
		end else begin
			el = el_aux;
		end
		reached   = (el >= wl);
		first     = (polls_q == 2'd0);
		late_full = unsigned'(el - wl);
		over      = (late_full > {{(TIME_W+1-PERIOD_W){1'b0}}, cfg.period_ns});
	end

	// Next wait and lateness at period end, with fractional carry
	always_comb begin
		frac_sum = {1'b0, frac_acc_q} + {1'b0, cfg.period_fraction};
		if (first && over) begin
			frac_in   = {1'b0, cfg.period_fraction};
			base_wait = {2'b00, cfg.period_ns[PERIOD_W-1:1]};
			end_late  = cfg.period_ns;
		end else if (first) begin
			frac_in   = frac_sum;
			base_wait = {1'b0, cfg.period_ns - late_full[PERIOD_W-1:0]};
			end_late  = late_full[PERIOD_W-1:0];
		end else begin
			frac_in   = frac_sum;
			base_wait = {1'b0, cfg.period_ns};
			end_late  = '0;
		end
		end_wait = base_wait + {{(WAIT_W-1){1'b0}}, frac_in[FRAC_W]};
	end

	// Select the state update and the result for this item
	always_comb begin
		result     = '0;
		latch_refs = 1'b0;
		wait_d     = wait_q;
		frac_d     = frac_acc_q;
		polls_d    = polls_q;
		if (item.operation == OP_RESTART) begin
			latch_refs = 1'b1;
			wait_d     = {1'b0, cfg.period_ns};
			frac_d     = '0;
			polls_d    = 2'd0;
		end else if (!reached) begin
			if (polls_q != 2'd3) begin
				polls_d = polls_q + 2'd1;
			end
		end else begin
			latch_refs         = 1'b1;
			wait_d             = end_wait;
			frac_d             = frac_in[FRAC_W-1:0];
			polls_d            = 2'd0;
			result.period_done = 1'b1;
			result.lateness_ns = end_late;
		end
		result.next_wait_ns = wait_d;
	end

	// Advance the state when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_ref_q <= '0;
			aux_ref_q  <= '0;
			wait_q     <= '0;
			frac_acc_q <= '0;
			polls_q    <= 2'd0;
		end else if (commit) begin
			if (latch_refs) begin
				main_ref_q <= item.main_time_ns;
				aux_ref_q  <= item.aux_time_ns;
			end
			wait_q     <= wait_d;
			frac_acc_q <= frac_d;
			polls_q    <= polls_d;
		end
	end

endmodule

`default_nettype wire

@@ src/fpp_checker.sv @@
// Port-level checker for the frame-period pacer, bound to the top level.
// Depends on fpp_pkg and frame_period_pacer_core.
`default_nettype none

module fpp_checker import fpp_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_payload
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed or dropped while stalled");

	// Input only stalls when a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// An accepted item reaches the result register once the output drains
	a_item_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted item produced no result");

	// Lateness is only reported at a period end
	a_late_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.period_done |-> out_payload.lateness_ns == '0)
		else $error("lateness without period end");

endmodule

bind frame_period_pacer_core fpp_checker u_fpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_payload (results.payload)
);

`default_nettype wire

@@ sim/tb_frame_period_pacer_core.sv @@
// Self-checking testbench for frame_period_pacer_core: directed and random items
// on the item channel, with results checked against a cycle-free pacer model.
// Depends on fpp_pkg, fpp_if and the pacer RTL.
`default_nettype none

module tb_frame_period_pacer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fpp_pkg::*;

	localparam int          IDLE_LIMIT = 3000;
	localparam int          SIDE_SEND  = 0;
	localparam int          SIDE_TAKE  = 1;
	localparam logic [62:0] TIME_MAX   = '1;

	// Pacer model: period registers, pacer state and the results still due
	class pacer_tracker;
		logic [PERIOD_W-1:0] period_ns       = '0;
		logic [FRAC_W-1:0]   period_fraction = '0;
		logic [TIME_W-1:0]   main_ref        = '0;
		logic [TIME_W-1:0]   aux_ref         = '0;
		logic [WAIT_W-1:0]   wait_len        = '0;
		logic [FRAC_W:0]     frac_acc        = '0;
		logic [1:0]          polls           = '0;
		result_t             due[$];
		int unsigned n_err = 0, n_checked = 0;
		int unsigned n_restart = 0, n_poll = 0, n_done = 0, n_late = 0;
		int unsigned n_capped = 0, n_carry = 0, n_aux = 0, n_sat = 0;

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PERIOD_NS:       period_ns = data;
				CFG_PERIOD_FRACTION: period_fraction = data[FRAC_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the pacer by one accepted item and queue its result
		function void note_item(item_t it);
			result_t want;
			longint  wl, el, lag;
			want = '0;
			if (it.operation == OP_RESTART) begin
				main_ref = it.main_time_ns;
				aux_ref  = it.aux_time_ns;
				wait_len = {1'b0, period_ns};
				frac_acc = '0;
				polls    = '0;
				n_restart++;
			end else begin
				n_poll++;
				wl = longint'({31'd0, wait_len});
				el = longint'({1'b0, it.main_time_ns}) - longint'({1'b0, main_ref});
				// fall back to the auxiliary clock on an implausible main reading
				if (el <= 0 || el > MAIN_LIMIT_NS) begin
					n_aux++;
					el = longint'({1'b0, it.aux_time_ns}) - longint'({1'b0, aux_ref});
					if (el < 0)
						el = wl;
				end
				if (el < wl) begin
					if (polls != 2'd3)
						polls++;
					else
						n_sat++;
				end else begin
					n_done++;
					want.period_done = 1'b1;
					main_ref = it.main_time_ns;
					aux_ref  = it.aux_time_ns;
					if (polls == 2'd0) begin
						lag = el - wl;
						if (lag > longint'({32'd0, period_ns})) begin
							// more than a whole period late: cap and halve
							n_capped++;
							wait_len          = {1'b0, period_ns >> 1};
							frac_acc          = '0;
							want.lateness_ns  = period_ns;
						end else begin
							if (lag != 0)
								n_late++;
							wait_len         = {1'b0, period_ns} - lag[WAIT_W-1:0];
							want.lateness_ns = lag[PERIOD_W-1:0];
						end
					end else begin
						wait_len = {1'b0, period_ns};
					end
					polls = '0;
					// add the fractional period, carry whole nanoseconds
					frac_acc = frac_acc + {1'b0, period_fraction};
					if (frac_acc[FRAC_W]) begin
						n_carry++;
						wait_len = wait_len + 1'b1;
						frac_acc[FRAC_W] = 1'b0;
					end
				end
			end
			want.next_wait_ns = wait_len;
			due.push_back(want);
		endfunction

		// Compare one accepted result with the oldest one due
		function void check_result(result_t got);
			result_t want;
			if (due.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result: done %0b lateness %0d next_wait %0d",
						got.period_done, got.lateness_ns, got.next_wait_ns);
				return;
			end
			want = due.pop_front();
			n_checked++;
			if (got.period_done !== want.period_done || got.lateness_ns !== want.lateness_ns
					|| got.next_wait_ns !== want.next_wait_ns) begin
				n_err++;
				if (n_err <= 10) begin
					$display("mismatch on result %0d (expected/actual):", n_checked);
					$display("  done %0b/%0b lateness %0d/%0d next_wait %0d/%0d",
						want.period_done, got.period_done, want.lateness_ns,
						got.lateness_ns, want.next_wait_ns, got.next_wait_ns);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fpp_item_if   items_ch ();
	fpp_result_if results_ch ();

	frame_period_pacer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch),
		.results   (results_ch)
	);

	pacer_tracker tracker;
	int unsigned  calm[2];
	int unsigned  idle_cycles;
	int unsigned  n_settings;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Draw the wait before the next item, with occasional runs of no waiting
	function automatic int unsigned draw_gap(int side);
		if (calm[side] > 0) begin
			calm[side]--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			calm[side] = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [62:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	// Sample register writes and both handshakes; watch for a stuck run
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.write_reg(cfg_index, cfg_wdata);
			if (items_ch.valid && items_ch.ready)
				tracker.note_item(items_ch.payload);
			if (results_ch.valid && results_ch.ready)
				tracker.check_result(results_ch.payload);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Result side: stall a random number of cycles before each result
	initial begin
		int unsigned gap;
		results_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap(SIDE_TAKE);
			if (gap > 0) begin
				results_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!(results_ch.valid && results_ch.ready));
		end
	end

	// Send one item; entered and left at a falling edge
	task automatic send_item(op_t op, logic [62:0] tm, logic [62:0] ta);
		int unsigned gap;
		gap = draw_gap(SIDE_SEND);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_ch.valid   <= 1'b1;
		items_ch.payload <= '{operation: op, main_time_ns: tm, aux_time_ns: ta};
		do @(posedge clk); while (!(items_ch.valid && items_ch.ready));
		@(negedge clk);
	endtask

	// Hold off until every queued result has come back, then let the pipe settle
	task automatic wait_all_done();
		items_ch.valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Poll aimed around the current wait, with main and aux clock faults mixed in
	task automatic send_poll();
		longint      wl, per, tgt;
		int unsigned r;
		logic [62:0] tm, ta;
		wl  = longint'({31'd0, tracker.wait_len});
		per = longint'({32'd0, tracker.period_ns});
		r   = $urandom_range(0, 99);
		if (r < 30)
			tgt = $urandom_range(0, 32'(wl / 2));
		else if (r < 55)
			tgt = wl + $urandom_range(0, 4) - 2;
		else if (r < 75)
			tgt = wl + $urandom_range(0, 32'(per));
		else if (r < 85)
			tgt = wl + per + 1 + $urandom_range(0, 32'(per));
		else
			tgt = $urandom_range(0, 32'(wl / 8));
		if (tgt < 0)
			tgt = 0;
		tm = tracker.main_ref + 63'(tgt);
		ta = tracker.aux_ref + 63'(tgt) - 63'($urandom_range(0, 3));
		r  = $urandom_range(0, 99);
		if (r < 6)
			tm = tracker.main_ref;
		else if (r < 12)
			tm = tracker.main_ref - 63'(1 + $urandom_range(0, 1000000));
		else if (r < 17)
			tm = tracker.main_ref + 63'(500000001) + 63'($urandom);
		else if (r < 20) begin
			tm = tracker.main_ref - 63'(1 + $urandom_range(0, 1000));
			ta = tracker.aux_ref - 63'(1 + $urandom_range(0, 1000));
		end
		send_item(OP_POLL, tm, ta);
	endtask

	// One setting: write both registers while idle, restart, then random items
	task automatic run_setting(logic [31:0] per, logic [15:0] frac, int n_items);
		int unsigned r;
		wait_all_done();
		write_reg(CFG_PERIOD_NS, per);
		write_reg(CFG_PERIOD_FRACTION, {16'd0, frac});
		n_settings++;
		send_item(OP_RESTART, rand_time(), rand_time());
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				send_item(op_t'($urandom_range(0, 1)), rand_time(), rand_time());
			else if (r < 7)
				send_item(OP_RESTART, rand_time(), rand_time());
			else if (r < 10)
				send_item(OP_RESTART, tracker.main_ref + 63'($urandom),
					tracker.aux_ref + 63'($urandom));
			else
				send_poll();
			if ($urandom_range(0, 249) == 0)
				wait_all_done();
		end
	endtask

	initial begin
		tracker          = new();
		calm[SIDE_SEND]  = 0;
		calm[SIDE_TAKE]  = 0;
		idle_cycles      = 0;
		n_settings       = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_PERIOD_NS;
		cfg_wdata        = '0;
		items_ch.valid   = 1'b0;
		items_ch.payload = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// poll before any restart: zero references and zero wait
		send_item(OP_POLL, 63'd5, 63'd7);
		wait_all_done();
		write_reg(CFG_PERIOD_NS, 32'd1000);
		write_reg(CFG_PERIOD_FRACTION, 32'h8000);
		send_item(OP_RESTART, 63'd0, 63'd0);
		// main reading of zero elapsed, then polls that saturate the count
		send_item(OP_POLL, 63'd0, 63'd0);
		send_item(OP_POLL, 63'd400, 63'd400);
		send_item(OP_POLL, 63'd700, 63'd700);
		send_item(OP_POLL, 63'd900, 63'd900);
		// period end on a later poll
		send_item(OP_POLL, 63'd1000, 63'd1000);
		// late first poll with fraction carry
		send_item(OP_POLL, 63'd2200, 63'd2200);
		// lateness over a whole period
		send_item(OP_POLL, 63'd4501, 63'd4501);
		// main shows no progress, aux decides
		send_item(OP_POLL, 63'd4501, 63'd5101);
		// both clocks step back
		send_item(OP_POLL, 63'd100, 63'd50);
		// main elapsed exactly at the plausibility limit
		send_item(OP_POLL, 63'd500000100, 63'd53);
		// main elapsed one past the limit
		send_item(OP_POLL, 63'd1000000101, 63'd73);
		send_item(OP_RESTART, TIME_MAX, TIME_MAX);
		send_item(OP_POLL, 63'd0, 63'd0);
		send_item(OP_POLL, TIME_MAX, TIME_MAX);
		send_item(OP_RESTART, 63'({32{2'b01}}), 63'({32{2'b10}}));
		send_item(OP_POLL, 63'({32{2'b10}}), 63'({32{2'b01}}));
		send_item(OP_RESTART, 63'd0, 63'd0);

		run_setting(32'd16666667, 16'h5555, 200);
		run_setting(32'd0, 16'h0000, 200);
		run_setting(32'hFFFF_FFFF, 16'hFFFF, 200);
		run_setting(32'd1, 16'hFFFF, 200);
		run_setting(32'd1000, 16'h8000, 200);
		run_setting($urandom_range(0, 400000000), 16'($urandom), 200);
		run_setting(32'd200000000, 16'h0001, 200);
		run_setting(32'd7, 16'hFFFF, 200);

		wait_all_done();
		repeat (8) @(negedge clk);
		$display("Covered %0d restarts and %0d polls over %0d period settings;",
			tracker.n_restart, tracker.n_poll, n_settings + 1);
		$display("%0d results checked, %0d period ends, %0d late first polls, %0d capped,",
			tracker.n_checked, tracker.n_done, tracker.n_late, tracker.n_capped);
		$display("%0d carries, %0d aux readings, %0d saturated polls.",
			tracker.n_carry, tracker.n_aux, tracker.n_sat);
		if (tracker.n_err == 0 && tracker.due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", tracker.n_err,
				tracker.due.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/fpp_pkg.sv
src/fpp_if.sv
src/fpp_cfg_regs.sv
src/fpp_pacer_step.sv
src/frame_period_pacer_core.sv
src/fpp_checker.sv
sim/tb_frame_period_pacer_core.sv
